### rtl/tpc_pkg.sv
package tpc_pkg;

  localparam int VIEW_WIDTH  = 640;
  localparam int VIEW_HEIGHT = 480;

  localparam int NumRegs    = 8;
  localparam int RegIdxW    = 3;
  localparam int DivStages  = 9;               // four quotient bits per stage
  localparam int RecipLat   = DivStages + 1;   // plus sign / saturate stage
  localparam int VertexLat  = RecipLat + 4;
  localparam int TopLat     = VertexLat + 1;   // plus cull / output stage

  localparam logic signed [63:0] OneQ16 = 64'sd65536;

  // m[r][c], signed Q16.16
  typedef logic [3:0][3:0][31:0] mat_t;
  typedef logic [2:0][31:0] vec3_t;

  typedef struct packed {
    logic signed [63:0] sx;
    logic signed [63:0] sy;
    logic               bad;
  } vtx_res_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

endpackage

### rtl/triangle_project_and_cull_top.sv
// Triangle projection and cull.
// Input channel: one transaction is one triangle, three vertices of signed
// Q16.16 x/y/z, taken when in_valid_i is high and in_stall_o is low.
// Output channel: one transaction per triangle, six saturated Q16.16 screen
// coordinates and a culled flag, taken when out_valid_o is high and
// out_stall_i is low. Results leave in input order.
// Pipeline stages, in order: the matrix products, the clip sums, the
// reciprocal of w (nine radix-16 restoring division stages and a
// sign/saturate stage), the perspective products, the viewport map and
// the bounding box test into the output register. Each vertex has its own
// datapath. Throughput is one triangle per cycle unless the output stalls.
// The whole pipeline advances together: while the output holds a transaction
// that the receiver stalls, every stage holds and in_stall_o is raised.
// Reset clears all valid bits and loads the identity matrix. Write matrix
// registers through cfg_we_i/cfg_idx_i/cfg_data_i only while the pipeline
// is empty.
module triangle_project_and_cull_top
  import tpc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [RegIdxW-1:0]   cfg_idx_i,
  input  logic [63:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [31:0]   vertex_a_x_i,
  input  logic signed [31:0]   vertex_a_y_i,
  input  logic signed [31:0]   vertex_a_z_i,
  input  logic signed [31:0]   vertex_b_x_i,
  input  logic signed [31:0]   vertex_b_y_i,
  input  logic signed [31:0]   vertex_b_z_i,
  input  logic signed [31:0]   vertex_c_x_i,
  input  logic signed [31:0]   vertex_c_y_i,
  input  logic signed [31:0]   vertex_c_z_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [31:0]   screen_a_x_o,
  output logic signed [31:0]   screen_a_y_o,
  output logic signed [31:0]   screen_b_x_o,
  output logic signed [31:0]   screen_b_y_o,
  output logic signed [31:0]   screen_c_x_o,
  output logic signed [31:0]   screen_c_y_o,
  output logic                 culled_o
);

  // matrix registers, two entries per register
  logic [63:0] cfg_q [NumRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[0] <= 64'h0000_0000_0001_0000;
      cfg_q[1] <= '0;
      cfg_q[2] <= 64'h0001_0000_0000_0000;
      cfg_q[3] <= '0;
      cfg_q[4] <= '0;
      cfg_q[5] <= 64'h0000_0000_0001_0000;
      cfg_q[6] <= '0;
      cfg_q[7] <= 64'h0001_0000_0000_0000;
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  mat_t mat;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        mat[r][c] = cfg_q[r * 2 + c / 2][(c % 2) * 32 +: 32];
      end
    end
  end

  // global advance: hold every stage while the output is stalled
  logic              en;
  logic [TopLat-1:0] vld_q;

  assign en         = !(vld_q[TopLat-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TopLat-2:0], in_valid_i};
    end
  end

  // one datapath per vertex
  vec3_t    vin [3];
  vtx_res_t vres [3];

  assign vin[0] = {vertex_a_z_i, vertex_a_y_i, vertex_a_x_i};
  assign vin[1] = {vertex_b_z_i, vertex_b_y_i, vertex_b_x_i};
  assign vin[2] = {vertex_c_z_i, vertex_c_y_i, vertex_c_x_i};

  for (genvar k = 0; k < 3; k++) begin : g_vtx
    tpc_vertex u_vertex (
      .clk_i (clk_i),
      .en_i  (en),
      .mat_i (mat),
      .v_i   (vin[k]),
      .res_o (vres[k])
    );
  end

  // bounding box against the screen, on unsaturated values
  logic signed [63:0] min_x, max_x, min_y, max_y;
  logic               cull_d;

  always_comb begin
    min_x = vres[0].sx;
    max_x = vres[0].sx;
    min_y = vres[0].sy;
    max_y = vres[0].sy;
    for (int k = 1; k < 3; k++) begin
      if (vres[k].sx < min_x) min_x = vres[k].sx;
      if (vres[k].sx > max_x) max_x = vres[k].sx;
      if (vres[k].sy < min_y) min_y = vres[k].sy;
      if (vres[k].sy > max_y) max_y = vres[k].sy;
    end
    cull_d = vres[0].bad || vres[1].bad || vres[2].bad
             || (max_x < 0) || (min_x > $signed(64'(VIEW_WIDTH)) * OneQ16)
             || (max_y < 0) || (min_y > $signed(64'(VIEW_HEIGHT)) * OneQ16);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      screen_a_x_o <= sat32(vres[0].sx);
      screen_a_y_o <= sat32(vres[0].sy);
      screen_b_x_o <= sat32(vres[1].sx);
      screen_b_y_o <= sat32(vres[1].sy);
      screen_c_x_o <= sat32(vres[2].sx);
      screen_c_y_o <= sat32(vres[2].sy);
      culled_o     <= cull_d;
    end
  end

  assign out_valid_o = vld_q[TopLat-1];

  // an accepted triangle enters the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted triangle lost at pipeline entry");

  // a stalled output freezes the whole valid chain
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(vld_q))
    else $error("pipeline moved under output stall");

  // input is only stalled when the output holds a transaction
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled without a waiting result");

endmodule

### rtl/tpc_recip.sv
module tpc_recip
  import tpc_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] w_i,
  output logic signed [31:0] inv_w_o,
  output logic               bad_o
);

  logic [32:0] rem_q  [DivStages];
  logic [35:0] quo_q  [DivStages];
  logic [31:0] div_q  [DivStages];
  logic        neg_q  [DivStages];
  logic        zero_q [DivStages];

  logic [31:0] d_in;
  assign d_in = w_i[31] ? 32'(-w_i) : w_i;

  // restoring division of 2^32 by |w|, four bits per stage
  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    localparam int Prev = (k == 0) ? 0 : k - 1;

    logic [32:0] r;
    logic [35:0] q;
    logic [31:0] d;
    logic        neg;
    logic        zero;

    always_comb begin
      if (k == 0) begin
        r    = '0;
        q    = '0;
        d    = d_in;
        neg  = w_i[31];
        zero = (w_i == '0);
      end else begin
        r    = rem_q[Prev];
        q    = quo_q[Prev];
        d    = div_q[Prev];
        neg  = neg_q[Prev];
        zero = zero_q[Prev];
      end
      for (int j = 0; j < 4; j++) begin
        r = {r[31:0], ((35 - 4 * k - j) == 32)};
        if (r >= {1'b0, d}) begin
          r = r - {1'b0, d};
          q = {q[34:0], 1'b1};
        end else begin
          q = {q[34:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= r;
        quo_q[k]  <= q;
        div_q[k]  <= d;
        neg_q[k]  <= neg;
        zero_q[k] <= zero;
      end
    end
  end

  logic [32:0]        mag;
  logic signed [31:0] inv_d;
  logic               bad_d;

  assign mag = quo_q[DivStages-1][32:0];

  always_comb begin
    if (zero_q[DivStages-1]) begin
      inv_d = 32'sh7fffffff;
    end else if (neg_q[DivStages-1]) begin
      inv_d = (mag > 33'h080000000) ? 32'sh80000000 : 32'(-mag);
    end else begin
      inv_d = (mag > 33'h07fffffff) ? 32'sh7fffffff : mag[31:0];
    end
    bad_d = zero_q[DivStages-1] || (inv_d > 32'sd65536) || (inv_d < -32'sd65536);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      inv_w_o <= inv_d;
      bad_o   <= bad_d;
    end
  end

endmodule

### rtl/tpc_vertex.sv
module tpc_vertex
  import tpc_pkg::*;
(
  input  logic     clk_i,
  input  logic     en_i,
  input  mat_t     mat_i,
  input  vec3_t    v_i,
  output vtx_res_t res_o
);

  // stage 1: matrix products
  logic signed [63:0] prod_q [4][3];
  logic signed [31:0] m3_q   [4];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= $signed(mat_i[r][c]) * $signed(v_i[c]);
        end
        m3_q[r] <= mat_i[r][3];
      end
    end
  end

  // stage 2: clip values, w term is exact
  logic signed [31:0] clip_q [4];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 4; r++) begin
        clip_q[r] <= sat32((prod_q[r][0] >>> 16) + (prod_q[r][1] >>> 16)
                           + (prod_q[r][2] >>> 16) + 64'(m3_q[r]));
      end
    end
  end

  // reciprocal of w, with x and y delayed alongside
  logic signed [31:0] inv_w;
  logic               bad;
  logic signed [31:0] cx_q [RecipLat];
  logic signed [31:0] cy_q [RecipLat];

  tpc_recip u_recip (
    .clk_i   (clk_i),
    .en_i    (en_i),
    .w_i     (clip_q[3]),
    .inv_w_o (inv_w),
    .bad_o   (bad)
  );

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q[0] <= clip_q[0];
      cy_q[0] <= clip_q[1];
      for (int i = 1; i < RecipLat; i++) begin
        cx_q[i] <= cx_q[i-1];
        cy_q[i] <= cy_q[i-1];
      end
    end
  end

  // perspective divide products
  logic signed [63:0] px_q, py_q;
  logic               bad_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q  <= cx_q[RecipLat-1] * inv_w;
      py_q  <= cy_q[RecipLat-1] * inv_w;
      bad_q <= bad;
    end
  end

  // viewport mapping
  logic signed [63:0] tx, ty;

  assign tx = ((px_q >>> 16) + OneQ16) * $signed(64'(VIEW_WIDTH));
  assign ty = (OneQ16 - (py_q >>> 16)) * $signed(64'(VIEW_HEIGHT));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o.sx  <= tx >>> 1;
      res_o.sy  <= ty >>> 1;
      res_o.bad <= bad_q;
    end
  end

endmodule
